// ===== rtl/sapb_pkg.sv =====
// Shared constants, command codes and controller/datapath handshake types
// for the servo actuator position bank. No dependencies.
package sapb_pkg;

  // Position format: unsigned fixed point, ONE_POS stands for 1.0.
  localparam int FRAC_BITS = 12;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam logic [POS_W-1:0] ONE_POS  = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] HALF_POS = POS_W'(1) << (FRAC_BITS - 1);

  // Field widths.
  localparam int KIND_W  = 4;
  localparam int ACT_W   = 3;
  localparam int PULSE_W = 16;
  localparam int PROD_W  = PULSE_W + POS_W;

  // Configuration: one step register per actuator, six in the map.
  localparam int NUM_STEP_REGS = 6;
  localparam int CFG_IDX_W     = 3;
  localparam logic [POS_W-1:0] STEP_RESET = POS_W'(410);
  localparam int NUM_ACTUATORS_DEF = 6;

  // Toggle thresholds: 10*pos compared against 4*ONE and 6*ONE.
  localparam int TOG_W = POS_W + 4;
  localparam logic [TOG_W-1:0] TOG_MUL = TOG_W'(10);
  localparam logic [TOG_W-1:0] TOG_LO  = TOG_W'(4) << FRAC_BITS;
  localparam logic [TOG_W-1:0] TOG_HI  = TOG_W'(6) << FRAC_BITS;

  // Trim division produces one quotient bit per cycle.
  localparam int DIV_STEPS = FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Command kinds.
  localparam logic [KIND_W-1:0] K_INC    = 4'd0;
  localparam logic [KIND_W-1:0] K_DEC    = 4'd1;
  localparam logic [KIND_W-1:0] K_MIN    = 4'd2;
  localparam logic [KIND_W-1:0] K_MAX    = 4'd3;
  localparam logic [KIND_W-1:0] K_CENTER = 4'd4;
  localparam logic [KIND_W-1:0] K_MINTOG = 4'd5;
  localparam logic [KIND_W-1:0] K_MAXTOG = 4'd6;
  localparam logic [KIND_W-1:0] K_TRIM   = 4'd7;
  localparam logic [KIND_W-1:0] K_PWM    = 4'd8;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic commit;
  } sapb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic out_free;
  } sapb_sts_t;

endpackage

// ===== rtl/sapb_ifs.sv =====
// Valid/ready channel interfaces for the command and result transactions.
// Depends on sapb_pkg.
interface sapb_cmd_if import sapb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ACT_W-1:0]   actuator;
  logic [PULSE_W-1:0] pulse_min;
  logic [PULSE_W-1:0] pulse_max;
  logic [PULSE_W-1:0] pulse_trim;

  modport source (output valid, kind, actuator, pulse_min, pulse_max, pulse_trim,
                  input ready);
  modport sink (input valid, kind, actuator, pulse_min, pulse_max, pulse_trim,
                output ready);
endinterface

interface sapb_res_if import sapb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   position;
  logic [PULSE_W-1:0] pulse_width;
  logic               pulse_valid;
  logic               ignored;

  modport source (output valid, position, pulse_width, pulse_valid, ignored,
                  input ready);
  modport sink (input valid, position, pulse_width, pulse_valid, ignored,
                output ready);
endinterface

// ===== rtl/sapb_ctrl.sv =====
// Sequencing state machine of the position bank: accept, execute, divide, deliver.
// Depends on sapb_pkg.
module sapb_ctrl import sapb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sapb_sts_t sts,
  output sapb_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_div) begin
          cnt_nxt   = CNT_W'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
        // Wait until the output register is free or being emptied.
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/sapb_dp.sv =====
// Datapath of the position bank: position store, step registers, trim divider,
// pulse multiplier and the result register. Depends on sapb_pkg and sapb_res_if.
module sapb_dp import sapb_pkg::*; #(
  parameter int NUM_ACTUATORS = NUM_ACTUATORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sapb_cmd_t            cmd,
  output sapb_sts_t            sts,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [ACT_W-1:0]     in_actuator,
  input  logic [PULSE_W-1:0]   in_pulse_min,
  input  logic [PULSE_W-1:0]   in_pulse_max,
  input  logic [PULSE_W-1:0]   in_pulse_trim,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  sapb_res_if.source           out_res
);

  localparam int IDX_W = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;

  logic [POS_W-1:0]   pos_r  [NUM_ACTUATORS];
  logic [POS_W-1:0]   step_r [NUM_ACTUATORS];

  logic [KIND_W-1:0]  kind_r;
  logic [ACT_W-1:0]   act_r;
  logic [PULSE_W-1:0] pmin_r;
  logic [PULSE_W-1:0] range_r;
  logic [PULSE_W-1:0] trim_r;
  logic [POS_W-1:0]   res_pos_r;
  logic [PULSE_W-1:0] rem_r;
  logic [PROD_W-1:0]  prod_r;

  logic [POS_W-1:0]   out_pos_r;
  logic [PULSE_W-1:0] out_pw_r;
  logic               out_pv_r;
  logic               out_ign_r;
  logic               out_valid_r;

  logic               bad;
  logic [IDX_W-1:0]   idx;
  logic [POS_W-1:0]   pos_cur;
  logic [POS_W-1:0]   step_cur;
  logic [POS_W:0]     inc_sum;
  logic [TOG_W-1:0]   pos_x10;
  logic [PULSE_W-1:0] diff;
  logic               trim_gt;
  logic [POS_W-1:0]   exec_pos;
  logic [PULSE_W:0]   rem_sh;
  logic               q_bit;
  logic [PULSE_W+1:0] pw_sum;
  logic [PULSE_W-1:0] pw_sat;

  assign bad      = {1'b0, act_r} >= (ACT_W + 1)'(NUM_ACTUATORS);
  assign idx      = bad ? '0 : act_r[IDX_W-1:0];
  assign pos_cur  = pos_r[idx];
  assign step_cur = step_r[idx];

  assign inc_sum = {1'b0, pos_cur} + {1'b0, step_cur};
  assign pos_x10 = TOG_W'(pos_cur) * TOG_MUL;
  assign trim_gt = trim_r > pmin_r;
  assign diff    = trim_r - pmin_r;

  // New position for the kinds that need no division; trim also settles its easy cases here.
  always_comb begin
    exec_pos = pos_cur;
    case (kind_r)
      K_INC:    exec_pos = (inc_sum > {1'b0, ONE_POS}) ? ONE_POS : inc_sum[POS_W-1:0];
      K_DEC:    exec_pos = (pos_cur >= step_cur) ? (pos_cur - step_cur) : '0;
      K_MIN:    exec_pos = '0;
      K_MAX:    exec_pos = ONE_POS;
      K_CENTER: exec_pos = HALF_POS;
      K_MINTOG: exec_pos = (pos_x10 < TOG_LO) ? HALF_POS : '0;
      K_MAXTOG: exec_pos = (pos_x10 >= TOG_HI) ? HALF_POS : ONE_POS;
      K_TRIM: begin
        if (range_r == '0 || !trim_gt) begin
          exec_pos = '0;
        end else if (diff >= range_r) begin
          exec_pos = ONE_POS;
        end else begin
          exec_pos = '0;
        end
      end
      default:  exec_pos = pos_cur;
    endcase
  end

  assign sts.need_div = (kind_r == K_TRIM) && !bad && (range_r != '0) && trim_gt &&
                        (diff < range_r);
  assign sts.out_free = !out_valid_r || out_res.ready;

  // One restoring division step: the remainder always stays below the range.
  assign rem_sh = {rem_r, 1'b0};
  assign q_bit  = rem_sh >= {1'b0, range_r};

  assign pw_sum = {2'b00, pmin_r} + (PULSE_W + 2)'(prod_r[PROD_W-1:FRAC_BITS]);
  assign pw_sat = (pw_sum[PULSE_W+1:PULSE_W] != 2'b00) ? {PULSE_W{1'b1}}
                                                        : pw_sum[PULSE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      act_r   <= in_actuator;
      pmin_r  <= in_pulse_min;
      range_r <= in_pulse_max - in_pulse_min;
      trim_r  <= in_pulse_trim;
    end
    if (cmd.exec) begin
      res_pos_r <= exec_pos;
      rem_r     <= diff;
      prod_r    <= PROD_W'(range_r) * PROD_W'(pos_cur);
    end else if (cmd.div_step) begin
      res_pos_r <= {res_pos_r[POS_W-2:0], q_bit};
      rem_r     <= q_bit ? PULSE_W'(rem_sh - {1'b0, range_r}) : rem_sh[PULSE_W-1:0];
    end
    if (cmd.commit) begin
      out_pos_r <= bad ? '0 : res_pos_r;
      out_pw_r  <= ((kind_r == K_PWM) && !bad) ? pw_sat : '0;
      out_pv_r  <= (kind_r == K_PWM) && !bad;
      out_ign_r <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ACTUATORS; i++) begin
        pos_r[i]  <= '0;
        step_r[i] <= STEP_RESET;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_ACTUATORS; i++) begin
        if (cmd.commit && !bad && (idx == IDX_W'(i))) begin
          pos_r[i] <= res_pos_r;
        end
        if (cfg_we && (i < NUM_STEP_REGS) && ({1'b0, cfg_index} == (CFG_IDX_W + 1)'(i))) begin
          step_r[i] <= cfg_data;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.position    = out_pos_r;
  assign out_res.pulse_width = out_pw_r;
  assign out_res.pulse_valid = out_pv_r;
  assign out_res.ignored     = out_ign_r;

endmodule

// ===== rtl/servo_actuator_position_bank_top.sv =====
// Top level of the servo actuator position bank: controller plus datapath.
// Depends on sapb_pkg, sapb_ifs, sapb_ctrl and sapb_dp.
//
// The block keeps one normalized position per actuator (4096 stands for 1.0).
// Each command transaction on in_cmd names an actuator and a kind: step up or
// down, snap to min, max or center, toggle, set from a trim pulse, or emit a
// pulse width. Exactly one result transaction leaves on out_res per command.
// Commands naming an actuator beyond the bank are flagged through ignored.
// The user is to write the step registers through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce
// this. An index past the last step register is dropped. A command is taken
// only while the controller is idle. Most kinds pass through the execute and
// done states; a trim command runs a restoring divider between them that
// produces one quotient bit per cycle. The controller returns to idle only
// once the result is committed, so a new command waits for the previous one.
// The pulse width comes from a registered multiply followed by an add with
// saturation. The result sits in an output register, so the next command is
// accepted while out_res is stalled; that command then waits to deliver
// until the register empties. Synchronous reset clears every position to
// zero, sets all steps to 410 and empties the output register.
module servo_actuator_position_bank_top import sapb_pkg::*; #(
  parameter int NUM_ACTUATORS = NUM_ACTUATORS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sapb_cmd_if.sink             in_cmd,
  sapb_res_if.source           out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data
);

  sapb_cmd_t cmd;
  sapb_sts_t sts;
  logic      in_ready;

  // The controller owns the input handshake.
  sapb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_cmd.ready = in_ready;

  // The datapath holds the position, step and result state and drives the result channel.
  sapb_dp #(
    .NUM_ACTUATORS (NUM_ACTUATORS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_cmd.kind),
    .in_actuator   (in_cmd.actuator),
    .in_pulse_min  (in_cmd.pulse_min),
    .in_pulse_max  (in_cmd.pulse_max),
    .in_pulse_trim (in_cmd.pulse_trim),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_res       (out_res)
  );

endmodule
